// File: rtl/core/drop_tail_server_queue_macros.svh
// ---------------------------------------------------------------------------
// drop tail server queue assertion macros
// shared concurrent assertion forms, clocked on i_clk, off while in reset
// ---------------------------------------------------------------------------
`ifndef DROP_TAIL_SERVER_QUEUE_MACROS_SVH
`define DROP_TAIL_SERVER_QUEUE_MACROS_SVH

// consequent checked in the same cycle as the antecedent
`define DTSQ_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// consequent checked in the cycle after the antecedent
`define DTSQ_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

// File: rtl/core/dtsq_pkg.sv
// ---------------------------------------------------------------------------
// dtsq_pkg
// types and constants shared by the drop tail server queue modules
// ---------------------------------------------------------------------------
package dtsq_pkg;

    localparam int DEF_RING_DEPTH = 64;
    localparam int DEF_TIME_BITS  = 48;

    // fixed field widths
    localparam int SVC_BITS  = 32;
    localparam int QLIM_BITS = 6;
    localparam logic [QLIM_BITS-1:0] QLIM_RESET = 6'd63;

    // configuration register indexes
    localparam logic REG_QUEUE_LIMIT = 1'b0;

    typedef enum logic {
        ST_IDLE,
        ST_CHECK
    } t_state;

    // controller to datapath
    typedef struct packed {
        logic accept;  // latch the incoming request
        logic pop;     // retire the job at the ring head
        logic finish;  // decide admission and load the result register
    } t_dp_cmd;

    // datapath to controller
    typedef struct packed {
        logic can_pop;   // head job finished at or before the arrival
        logic out_free;  // result register can take a new result
    } t_dp_status;

endpackage

// File: rtl/core/dtsq_ram.sv
// ---------------------------------------------------------------------------
// dtsq_ram
// generic single write port, single read port ram with registered read
// ---------------------------------------------------------------------------
module dtsq_ram #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// File: rtl/core/dtsq_ctrl.sv
// ---------------------------------------------------------------------------
// dtsq_ctrl
// controller: takes a request, retires finished jobs, then issues the decision
// ---------------------------------------------------------------------------
module dtsq_ctrl
    import dtsq_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    input  t_dp_status i_status,
    output logic       o_in_ready,
    output t_dp_cmd    o_cmd
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    n_state = ST_CHECK;
                end
            end
            ST_CHECK: begin
                if (!i_status.can_pop && i_status.out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        o_in_ready = 1'b0;
        o_cmd      = '0;
        case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                o_cmd.accept = i_in_valid;
            end
            ST_CHECK: begin
                o_cmd.pop    = i_status.can_pop;
                o_cmd.finish = !i_status.can_pop && i_status.out_free;
            end
            default: begin
                o_in_ready = 1'b0;
            end
        endcase
    end

endmodule

// File: rtl/core/dtsq_datapath.sv
// ---------------------------------------------------------------------------
// dtsq_datapath
// finish time ring, head and occupancy, admission arithmetic, result register
// ---------------------------------------------------------------------------
module dtsq_datapath
    import dtsq_pkg::*;
#(
    parameter int RING_DEPTH = DEF_RING_DEPTH,
    parameter int TIME_BITS  = DEF_TIME_BITS
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  t_dp_cmd              i_cmd,
    input  logic [TIME_BITS-1:0] i_arrival_time,
    input  logic [SVC_BITS-1:0]  i_service_time,
    input  logic [QLIM_BITS-1:0] i_queue_limit,
    input  logic                 i_out_ready,
    output t_dp_status           o_status,
    output logic                 o_out_valid,
    output logic                 o_accepted,
    output logic [TIME_BITS-1:0] o_finish_time
);

    localparam int AW = $clog2(RING_DEPTH);
    localparam int CW = $clog2(RING_DEPTH + 1);
    localparam int LW = (CW > QLIM_BITS) ? CW : QLIM_BITS;
    localparam int SW = ((TIME_BITS > SVC_BITS) ? TIME_BITS : SVC_BITS) + 1;
    localparam logic [TIME_BITS-1:0] TIME_MAX = {TIME_BITS{1'b1}};

    logic [AW-1:0]        r_head;
    logic [CW-1:0]        r_jobs;
    logic [TIME_BITS-1:0] r_last;
    logic [TIME_BITS-1:0] r_arr;
    logic [TIME_BITS-1:0] r_start;
    logic [SVC_BITS-1:0]  r_svc;
    logic                 r_out_valid;
    logic                 r_out_acc;
    logic [TIME_BITS-1:0] r_out_fin;

    logic [AW-1:0]        head_inc;
    logic [AW:0]          tail_sum;
    logic [AW-1:0]        tail;
    logic [AW-1:0]        raddr;
    logic [TIME_BITS-1:0] ring_q;
    logic [SW-1:0]        fin_sum;
    logic [TIME_BITS-1:0] fin;
    logic                 reject;
    logic                 admit;

    // next head with wrap, also the lookahead read address while popping
    assign head_inc = (r_head == AW'(RING_DEPTH - 1)) ? '0 : r_head + 1'b1;
    assign raddr    = i_cmd.pop ? head_inc : r_head;

    // tail slot; occupancy is below depth whenever a job is written
    assign tail_sum = (AW + 1)'(r_head) + (AW + 1)'(r_jobs);
    assign tail     = (tail_sum >= (AW + 1)'(RING_DEPTH))
                    ? AW'(tail_sum - (AW + 1)'(RING_DEPTH)) : tail_sum[AW-1:0];

    // saturating finish time
    assign fin_sum = SW'(r_start) + SW'(r_svc);
    assign fin     = (fin_sum[SW-1:TIME_BITS] != '0) ? TIME_MAX : fin_sum[TIME_BITS-1:0];

    assign reject = (LW'(r_jobs) > LW'(i_queue_limit))
                 || (r_jobs >= CW'(RING_DEPTH));
    assign admit  = i_cmd.finish && !reject;

    dtsq_ram #(
        .WIDTH (TIME_BITS),
        .DEPTH (RING_DEPTH)
    ) u_ring (
        .i_clk   (i_clk),
        .i_we    (admit),
        .i_waddr (tail),
        .i_wdata (fin),
        .i_raddr (raddr),
        .o_rdata (ring_q)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head      <= '0;
            r_jobs      <= '0;
            r_last      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.pop) begin
                r_head <= head_inc;
                r_jobs <= r_jobs - 1'b1;
            end else if (admit) begin
                r_jobs <= r_jobs + 1'b1;
                r_last <= fin;
            end
            if (i_cmd.finish) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // request and result payload
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_arr   <= i_arrival_time;
            r_svc   <= i_service_time;
            r_start <= (i_arrival_time > r_last) ? i_arrival_time : r_last;
        end
        if (i_cmd.finish) begin
            r_out_acc <= !reject;
            r_out_fin <= reject ? '0 : fin;
        end
    end

    assign o_status.can_pop  = (r_jobs != '0) && (ring_q <= r_arr);
    assign o_status.out_free = !r_out_valid || i_out_ready;

    assign o_out_valid   = r_out_valid;
    assign o_accepted    = r_out_acc;
    assign o_finish_time = r_out_fin;

endmodule

// File: rtl/core/drop_tail_server_queue.sv
// ---------------------------------------------------------------------------
// drop_tail_server_queue
// single server with a bounded fifo waiting room that drops new jobs when full
// ---------------------------------------------------------------------------
// usage:
//   s_axis carries one job per request: arrival time (nondecreasing) and
//   service time. m_axis returns one result per job: tuser says whether the
//   job was admitted, tdata holds its finish time (zero when dropped).
//   the apb port holds queue_limit at byte address 0; the user must write it
//   only while the block is idle, and the block does not enforce this.
// operation:
//   a request is taken in the idle state; in the check state finished jobs
//   are retired from the ring on its arrival, then it is decided, and only
//   then is a new request taken. the result shows on m_axis in the cycle
//   after the decision. retirement walks the finish ring one entry a cycle
//   through the ram's single read port, the next head read ahead on a pop.
// reset:
//   synchronous, active low: the ring is empty, last finish is zero and
//   queue_limit is 63. ring contents are not cleared, only occupancy.
// stalls:
//   while m_axis_tready is low a finished result waits in the output
//   register; the next request is still taken and retired against the ring,
//   and only its decision waits for the output register to free up.
// ---------------------------------------------------------------------------
`include "drop_tail_server_queue_macros.svh"

module drop_tail_server_queue
    import dtsq_pkg::*;
#(
    parameter int RING_DEPTH = DEF_RING_DEPTH,
    parameter int TIME_BITS  = DEF_TIME_BITS,
    localparam int IN_W  = ((TIME_BITS + SVC_BITS + 7) / 8) * 8,
    localparam int OUT_W = ((TIME_BITS + 7) / 8) * 8
) (
    input  logic             i_clk,
    input  logic             i_rst_n,

    // job requests
    input  logic             s_axis_tvalid,
    output logic             s_axis_tready,
    input  logic [IN_W-1:0]  s_axis_tdata,   // arrival_time, service_time

    // results
    output logic             m_axis_tvalid,
    input  logic             m_axis_tready,
    output logic [OUT_W-1:0] m_axis_tdata,   // finish_time
    output logic             m_axis_tuser,   // accepted

    // configuration
    input  logic             psel,
    input  logic             penable,
    input  logic             pwrite,
    input  logic [2:0]       paddr,
    input  logic [31:0]      pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);

    t_dp_cmd              cmd;
    t_dp_status           status;
    logic [QLIM_BITS-1:0] r_queue_limit;
    logic                 cfg_write;
    logic [TIME_BITS-1:0] finish_time;

    // register file: a single register, the waiting room limit
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready && (paddr[2] == REG_QUEUE_LIMIT);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_queue_limit <= QLIM_RESET;
        end else if (cfg_write) begin
            r_queue_limit <= pwdata[QLIM_BITS-1:0];
        end
    end

    assign prdata = (paddr[2] == REG_QUEUE_LIMIT) ? 32'(r_queue_limit) : '0;

    dtsq_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .i_status   (status),
        .o_in_ready (s_axis_tready),
        .o_cmd      (cmd)
    );

    dtsq_datapath #(
        .RING_DEPTH (RING_DEPTH),
        .TIME_BITS  (TIME_BITS)
    ) u_datapath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .i_arrival_time (s_axis_tdata[TIME_BITS-1:0]),
        .i_service_time (s_axis_tdata[TIME_BITS+SVC_BITS-1:TIME_BITS]),
        .i_queue_limit  (r_queue_limit),
        .i_out_ready    (m_axis_tready),
        .o_status       (status),
        .o_out_valid    (m_axis_tvalid),
        .o_accepted     (m_axis_tuser),
        .o_finish_time  (finish_time)
    );

    // zero padding up to whole bytes
    assign m_axis_tdata = OUT_W'(finish_time);

    // a request is held for at least its decision cycle
    `DTSQ_ASSERT_NEXT(a_busy_after_request, s_axis_tvalid && s_axis_tready, !s_axis_tready, "request taken while previous one still open")
    // a dropped job reports no finish time
    `DTSQ_ASSERT_SAME(a_drop_zero_finish, m_axis_tvalid && !m_axis_tuser, finish_time == '0, "dropped job carries a finish time")
    // a new result appears only after a decision
    `DTSQ_ASSERT_SAME(a_result_from_decision, $rose(m_axis_tvalid), $past(cmd.finish), "result valid without a decision")

endmodule

// File: sim/testbench.sv
// ---------------------------------------------------------------------------
// drop_tail_server_queue testbench
// job requests go in on s_axis and verdicts are checked on m_axis against a
// behavioural model of the single server queue; queue_limit is swept over apb
// ---------------------------------------------------------------------------
module testbench
    import dtsq_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int TIME_BITS  = DEF_TIME_BITS;
    localparam int RING_SLOTS = DEF_RING_DEPTH;
    localparam int IN_W       = ((TIME_BITS + SVC_BITS + 7) / 8) * 8;
    localparam int OUT_W      = ((TIME_BITS + 7) / 8) * 8;
    localparam logic [TIME_BITS-1:0] TIME_TOP = '1;
    localparam logic [SVC_BITS-1:0]  SVC_TOP  = '1;
    localparam logic [2:0] QLIM_ADDR = 3'(4 * int'(REG_QUEUE_LIMIT));
    localparam int LONG_HOLD = 400;

    // one job request, arrival in the low bits
    typedef struct packed {
        logic [SVC_BITS-1:0]  service;
        logic [TIME_BITS-1:0] arrival;
    } t_job;

    // one verdict as the block should report it
    typedef struct packed {
        logic                 admitted;
        logic [TIME_BITS-1:0] finish;
    } t_verdict;

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    logic             s_axis_tvalid = 1'b0;
    logic             s_axis_tready;
    logic [IN_W-1:0]  s_axis_tdata  = '0;   // arrival_time, service_time
    logic             m_axis_tvalid;
    logic             m_axis_tready = 1'b0;
    logic [OUT_W-1:0] m_axis_tdata;         // finish_time
    logic             m_axis_tuser;         // accepted

    logic        psel    = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite  = 1'b0;
    logic [2:0]  paddr   = '0;
    logic [31:0] pwdata  = '0;
    logic [31:0] prdata;
    logic        pready;

    drop_tail_server_queue u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    always #2 i_clk = ~i_clk;

    // -----------------------------------------------------------------------
    // queue model: finish times of the jobs in the system, oldest first
    // -----------------------------------------------------------------------
    logic [TIME_BITS-1:0] done_at [RING_SLOTS];
    logic [5:0]           oldest      = '0;
    int unsigned          occupancy   = 0;
    logic [TIME_BITS-1:0] latest_done = '0;
    logic [QLIM_BITS-1:0] room_limit  = QLIM_RESET;

    // retire, decide admission, and book the job into the ring
    function automatic t_verdict admit_job(input t_job job);
        t_verdict             v;
        logic [TIME_BITS-1:0] start;
        logic [TIME_BITS:0]   total;
        // a job finishing exactly at the arrival instant counts as gone
        while (occupancy != 0 && done_at[oldest] <= job.arrival) begin
            oldest    = oldest + 1'b1;
            occupancy = occupancy - 1;
        end
        // drop tail: waiting room or ring full
        if (occupancy > room_limit || occupancy >= RING_SLOTS) begin
            v.admitted = 1'b0;
            v.finish   = '0;
            return v;
        end
        // late arrivals still start no earlier than the last booked finish
        start = (job.arrival > latest_done) ? job.arrival : latest_done;
        total = {1'b0, start} + (TIME_BITS + 1)'(job.service);
        v.admitted = 1'b1;
        v.finish   = total[TIME_BITS] ? TIME_TOP : total[TIME_BITS-1:0];
        done_at[6'(oldest + occupancy)] = v.finish;
        occupancy   = occupancy + 1;
        latest_done = v.finish;
        return v;
    endfunction

    t_job     pending_jobs[$];      // requests not yet offered
    t_verdict due_verdicts[$];      // verdicts owed by the block, oldest first

    int n_sent     = 0;
    int n_results  = 0;
    int n_admitted = 0;
    int n_dropped  = 0;
    int n_errors   = 0;
    int n_settings = 0;

    // -----------------------------------------------------------------------
    // driver: bursts of requests with random gaps in between
    // -----------------------------------------------------------------------
    t_job job_on_bus;
    int   burst_left = 1;
    int   gap_left   = 0;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata  <= '0;
        end else begin
            // request taken at this edge: the model moves on with it
            if (s_axis_tvalid && s_axis_tready) begin
                due_verdicts.push_back(admit_job(job_on_bus));
                n_sent++;
            end
            if (!s_axis_tvalid || s_axis_tready) begin
                if (gap_left != 0) begin
                    gap_left      <= gap_left - 1;
                    s_axis_tvalid <= 1'b0;
                end else if (pending_jobs.size() != 0) begin
                    job_on_bus = pending_jobs.pop_front();
                    s_axis_tvalid <= 1'b1;
                    s_axis_tdata  <= IN_W'(job_on_bus);
                    if (burst_left <= 1) begin
                        // a third of the bursts run straight into the next
                        burst_left <= $urandom_range(1, 24);
                        gap_left   <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
                    end else begin
                        burst_left <= burst_left - 1;
                    end
                end else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // -----------------------------------------------------------------------
    // monitor: checks each verdict and drives the receiver's stall pattern
    // -----------------------------------------------------------------------
    logic hold_req  = 1'b0;         // raised once by the stimulus
    logic hold_done = 1'b0;
    int   hold_left = 0;
    int   rx_mode   = 0;
    int   mode_left = 0;
    t_verdict want;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                n_results++;
                if (m_axis_tuser) n_admitted++;
                else n_dropped++;
                if (due_verdicts.size() == 0) begin
                    $error("result with no request outstanding: accepted %0b finish_time %0h",
                           m_axis_tuser, m_axis_tdata);
                    n_errors++;
                end else begin
                    want = due_verdicts.pop_front();
                    if (m_axis_tuser !== want.admitted) begin
                        $error("accepted: expected %0b, got %0b", want.admitted, m_axis_tuser);
                        n_errors++;
                    end
                    if (m_axis_tdata[TIME_BITS-1:0] !== want.finish) begin
                        $error("finish_time: expected %0h, got %0h",
                               want.finish, m_axis_tdata[TIME_BITS-1:0]);
                        n_errors++;
                    end
                end
            end
            // one long hold-off so the block backs up and stalls its input
            if (hold_left != 0) begin
                hold_left     <= hold_left - 1;
                m_axis_tready <= 1'b0;
            end else if (hold_req && !hold_done) begin
                hold_left     <= LONG_HOLD;
                hold_done     <= 1'b1;
                m_axis_tready <= 1'b0;
            end else begin
                // modes: always ready, coin toss, mostly stalled
                if (mode_left == 0) begin
                    rx_mode   <= $urandom_range(0, 2);
                    mode_left <= $urandom_range(8, 64);
                end else begin
                    mode_left <= mode_left - 1;
                end
                case (rx_mode)
                    0:       m_axis_tready <= 1'b1;
                    1:       m_axis_tready <= 1'($urandom_range(0, 1));
                    default: m_axis_tready <= ($urandom_range(0, 3) == 0);
                endcase
            end
        end
    end

    // -----------------------------------------------------------------------
    // stimulus
    // -----------------------------------------------------------------------
    logic [TIME_BITS-1:0] arr_now = '0;   // running arrival clock

    task automatic set_queue_limit(input logic [QLIM_BITS-1:0] limit);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= QLIM_ADDR;
        pwdata  <= 32'(limit);
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        room_limit = limit;
        n_settings++;
        @(negedge i_clk);
    endtask

    task automatic queue_job(input logic [TIME_BITS-1:0] arrival,
                             input logic [SVC_BITS-1:0] service);
        t_job job;
        job.arrival = arrival;
        job.service = service;
        pending_jobs.push_back(job);
        arr_now = arrival;
    endtask

    function automatic logic [SVC_BITS-1:0] SVC_SIZE_RAND();
        return $urandom;
    endfunction

    // mostly a forward running arrival clock; some late arrivals as noise,
    // some long jumps so that huge service times drain away again
    task automatic make_traffic(input int n_jobs, input int gap_max, input int svc_max);
        int                   pick;
        t_job                 job;
        for (int k = 0; k < n_jobs; k++) begin
            pick = $urandom_range(0, 99);
            if (pick < 4) begin
                job.arrival = arr_now - TIME_BITS'($urandom_range(0, 40));
            end else begin
                if (pick < 8) arr_now = arr_now + TIME_BITS'({$urandom_range(0, 3), $urandom});
                else arr_now = arr_now + TIME_BITS'($urandom_range(0, gap_max));
                job.arrival = arr_now;
            end
            job.service = ($urandom_range(0, 99) < 4) ? SVC_SIZE_RAND() : $urandom_range(0, svc_max);
            pending_jobs.push_back(job);
        end
    endtask

    // waits at the falling edge until every request has its verdict back
    task automatic wait_drained();
        do @(negedge i_clk);
        while (pending_jobs.size() != 0 || s_axis_tvalid || due_verdicts.size() != 0);
    endtask

    logic [TIME_BITS-1:0] base;

    initial begin
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // reset limit: zero times, finish equal to arrival, huge service,
        // a late arrival, then a long jump that empties the system
        queue_job(0, 0);
        queue_job(0, 10);
        queue_job(5, 10);
        queue_job(10, 1);
        queue_job(30, 0);
        queue_job(30, SVC_TOP);
        queue_job(20, 3);
        base = TIME_BITS'(64'h2_0000_0000);
        queue_job(base, 1);
        wait_drained();

        // no waiting room: admitted only into an empty system
        set_queue_limit(0);
        queue_job(base + 10, 100);
        queue_job(base + 11, 5);
        queue_job(base + 110, 5);
        queue_job(base + 112, 0);
        queue_job(base + 115, 0);
        queue_job(base + 115, 7);
        wait_drained();

        // one waiting place
        set_queue_limit(1);
        queue_job(base + 200, 50);
        queue_job(base + 201, 50);
        queue_job(base + 202, 50);
        queue_job(base + 250, 10);
        queue_job(base + 251, 0);
        wait_drained();

        // random traffic over several limits; congested phases fill the ring
        set_queue_limit(63);
        make_traffic(250, 8, 30);
        hold_req = 1'b1;
        wait_drained();

        set_queue_limit(0);
        make_traffic(150, 40, 20);
        wait_drained();

        set_queue_limit(QLIM_BITS'($urandom_range(2, 62)));
        make_traffic(200, 6, 25);
        wait_drained();

        set_queue_limit(1);
        make_traffic(150, 20, 20);
        wait_drained();

        set_queue_limit(QLIM_BITS'($urandom_range(0, 63)));
        make_traffic(200, 10, 20);
        wait_drained();

        set_queue_limit(63);
        make_traffic(250, 30, 20);
        wait_drained();

        // top of the time range last: saturation pins the last finish there
        queue_job(TIME_TOP - 1000, 500);
        queue_job(TIME_TOP - 900, SVC_TOP);
        queue_job(TIME_TOP - 800, 0);
        queue_job(TIME_TOP - 1, 5);
        queue_job(TIME_TOP, 0);
        queue_job(TIME_TOP, SVC_TOP);
        wait_drained();

        set_queue_limit(0);
        queue_job(TIME_TOP - 5, 0);
        queue_job(TIME_TOP, 9);
        for (int k = 0; k < 10; k++) begin
            queue_job(($urandom_range(0, 1) == 1) ? TIME_TOP
                                                  : TIME_TOP - TIME_BITS'($urandom_range(1, 100)),
                      $urandom);
        end
        wait_drained();

        // let any stray result show up before closing
        repeat (20) @(posedge i_clk);

        $display("%0d job requests over %0d queue_limit settings, %0d results checked",
                 n_sent, n_settings, n_results);
        $display("%0d jobs admitted, %0d dropped, %0d mismatches", n_admitted, n_dropped,
                 n_errors);
        if (n_errors == 0 && due_verdicts.size() == 0) begin
            $display("drop_tail_server_queue test passed");
        end else begin
            $display("drop_tail_server_queue test failed");
        end
        $finish;
    end

    // watchdog well beyond the slowest legal run
    initial begin
        #2_000_000;
        $display("drop_tail_server_queue test failed");
        $finish;
    end

endmodule

// File: drop_tail_server_queue.f
+incdir+rtl/core
rtl/core/dtsq_pkg.sv
rtl/core/dtsq_ram.sv
rtl/core/dtsq_ctrl.sv
rtl/core/dtsq_datapath.sv
rtl/core/drop_tail_server_queue.sv
sim/testbench.sv
